FILE: hdl/cps_pkg.sv
package cps_pkg;

    localparam int ATAN_ENTRIES = 24;
    localparam int SQRT_STEPS   = 16;

    localparam int XY_W   = 34;
    localparam int Z_W    = 33;
    localparam int ROOT_W = 16;
    localparam int REM_W  = 19;
    localparam int HGT_W  = 24;

    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'h26DD3B6A;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef enum logic [2:0] {
        REG_ROW_X  = 3'd0,
        REG_ROW_Y  = 3'd1,
        REG_ROW_Z  = 3'd2,
        REG_OFFSET = 3'd3,
        REG_ORIGIN = 3'd4,
        REG_RADIUS = 3'd5,
        REG_HEIGHT = 3'd6
    } reg_index_t;

    // one item as it travels through the sqrt / cordic stages
    typedef struct packed {
        logic                    valid;
        logic [15:0]             slot;
        logic [HGT_W-1:0]        height;
        logic [1:0]              quad;
        logic [15:0]             frac_r;
        logic [REM_W-1:0]        rem;
        logic [ROOT_W-1:0]       root;
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [Z_W-1:0]   z;
    } kern_t;

    // arctangent of 2^-i in units of 2^32 per turn
    function automatic logic [31:0] atan_turn(input int unsigned idx);
        logic [31:0] v;
        unique case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2F9;
            15: v = 32'h0000517C;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A2F;
            19: v = 32'h00000517;
            20: v = 32'h0000028B;
            21: v = 32'h00000145;
            22: v = 32'h000000A2;
            23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/cylinder_point_sample_transform.sv
// channel  | handshake          | payload
// ---------+--------------------+---------------------------------------------
// input    | start, busy        | slot, frac_height, frac_radius, frac_angle
// result   | done (strobe)      | out_slot, pos_x, pos_y, pos_z
// config   | wr_en              | wr_index, wr_data
//
// one transaction per cycle; busy stays low
// each item passes an input register, one sqrt/cordic stage per iteration,
// then six transform stages
// rst_n clears valid bits and loads the identity transform, unit radius/height
// results come out in order and cannot be held off
module cylinder_point_sample_transform
    import cps_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] slot,
    input  logic [15:0] frac_height,
    input  logic [15:0] frac_radius,
    input  logic [15:0] frac_angle,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [47:0] wr_data,
    output logic        done,
    output logic [15:0] out_slot,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z
);

    logic [47:0] row_x_reg, row_y_reg, row_z_reg, offset_reg, origin_reg;
    logic [15:0] radius_reg, height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg  <= 48'h0000_0000_4000;
            row_y_reg  <= 48'h0000_4000_0000;
            row_z_reg  <= 48'h4000_0000_0000;
            offset_reg <= 48'h0;
            origin_reg <= 48'h0;
            radius_reg <= 16'h0100;
            height_reg <= 16'h0100;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_ROW_X:  row_x_reg  <= wr_data;
                REG_ROW_Y:  row_y_reg  <= wr_data;
                REG_ROW_Z:  row_z_reg  <= wr_data;
                REG_OFFSET: offset_reg <= wr_data;
                REG_ORIGIN: origin_reg <= wr_data;
                REG_RADIUS: radius_reg <= wr_data[15:0];
                REG_HEIGHT: height_reg <= wr_data[15:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    kern_t in_reg;
    kern_t in_next;
    logic [31:0] hgt_prod;

    assign hgt_prod = height_reg * frac_height;

    always_comb
    begin
        in_next.valid  = start & ~busy;
        in_next.slot   = slot;
        in_next.height = hgt_prod[31:8];
        in_next.quad   = frac_angle[15:14];
        in_next.frac_r = frac_radius;
        in_next.rem    = '0;
        in_next.root   = '0;
        in_next.x      = $signed({2'b00, CORDIC_GAIN_Q30});
        in_next.y      = '0;
        in_next.z      = $signed({3'b000, frac_angle[13:0], 16'b0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_reg.valid <= 1'b0;
        end
        else
        begin
            in_reg <= in_next;
        end
    end

    kern_t kern_out;

    cps_kernel #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_kernel (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage_in  (in_reg),
        .stage_out (kern_out)
    );

    cps_xform u_xform (
        .clk      (clk),
        .rst_n    (rst_n),
        .kin      (kern_out),
        .row_x    (row_x_reg),
        .row_y    (row_y_reg),
        .row_z    (row_z_reg),
        .offset   (offset_reg),
        .origin   (origin_reg),
        .radius   (radius_reg),
        .done     (done),
        .out_slot (out_slot),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .pos_z    (pos_z)
    );

endmodule

FILE: hdl/cps_kernel.sv
module cps_kernel
    import cps_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic  clk,
    input  logic  rst_n,
    input  kern_t stage_in,
    output kern_t stage_out
);

    localparam int NSTG = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;

    kern_t stage_reg  [1:NSTG];
    kern_t stage_next [0:NSTG-1];

    genvar k;
    generate
        for (k = 0; k < NSTG; k++) begin : g_stage
            kern_t cur;
            logic [1:0] pair;
            logic [REM_W-1:0] rem_sh;
            logic [REM_W-1:0] trial;

            if (k == 0) begin : g_first
                assign cur = stage_in;
            end else begin : g_rest
                assign cur = stage_reg[k];
            end

            // radicand is frac_r followed by sixteen zero bits
            if (k < 8) begin : g_bits
                assign pair = cur.frac_r[15-2*k -: 2];
            end else begin : g_zero
                assign pair = 2'b00;
            end

            assign rem_sh = {cur.rem[REM_W-3:0], pair};
            assign trial  = {1'b0, cur.root, 2'b01};

            always_comb
            begin
                stage_next[k] = cur;
                if (k < SQRT_STEPS)
                begin
                    if (rem_sh >= trial)
                    begin
                        stage_next[k].rem  = rem_sh - trial;
                        stage_next[k].root = {cur.root[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        stage_next[k].rem  = rem_sh;
                        stage_next[k].root = {cur.root[ROOT_W-2:0], 1'b0};
                    end
                end
                if (k < CORDIC_STAGES && k < ATAN_ENTRIES)
                begin
                    if (cur.z >= 0)
                    begin
                        stage_next[k].x = cur.x - (cur.y >>> k);
                        stage_next[k].y = cur.y + (cur.x >>> k);
                        stage_next[k].z = cur.z - $signed({1'b0, atan_turn(k)});
                    end
                    else
                    begin
                        stage_next[k].x = cur.x + (cur.y >>> k);
                        stage_next[k].y = cur.y - (cur.x >>> k);
                        stage_next[k].z = cur.z + $signed({1'b0, atan_turn(k)});
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    stage_reg[k+1].valid <= 1'b0;
                end
                else
                begin
                    stage_reg[k+1] <= stage_next[k];
                end
            end
        end
    endgenerate

    assign stage_out = stage_reg[NSTG];

`ifndef SYNTHESIS
    a_valid_kept: assert property (@(posedge clk) disable iff (!rst_n)
        stage_in.valid |-> ##NSTG stage_out.valid)
        else $error("valid bit lost in kernel");

    a_valid_delay: assert property (@(posedge clk) disable iff (!rst_n)
        stage_out.valid |-> $past(stage_in.valid, NSTG))
        else $error("valid bit invented in kernel");

    a_root_low: assert property (@(posedge clk) disable iff (!rst_n)
        stage_out.valid |->
            ({16'b0, stage_out.root} * {16'b0, stage_out.root}) <= {stage_out.frac_r, 16'b0})
        else $error("square root too large");

    a_root_high: assert property (@(posedge clk) disable iff (!rst_n)
        stage_out.valid |->
            ({16'b0, stage_out.root} + 33'd1) * ({16'b0, stage_out.root} + 33'd1)
                > {17'b0, stage_out.frac_r, 16'b0})
        else $error("square root too small");
`endif

endmodule

FILE: hdl/cps_xform.sv
module cps_xform
    import cps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  kern_t        kin,
    input  logic [47:0]  row_x,
    input  logic [47:0]  row_y,
    input  logic [47:0]  row_z,
    input  logic [47:0]  offset,
    input  logic [47:0]  origin,
    input  logic [15:0]  radius,
    output logic         done,
    output logic [15:0]  out_slot,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z
);

    localparam int LW = 28;
    localparam int PW = 44;
    localparam int AW = 47;

    // stage 1: distance and quadrant fold
    logic               v1_reg;
    logic [15:0]        slot1_reg;
    logic [23:0]        dist1_reg;
    logic signed [31:0] c1_reg, s1_reg;
    logic signed [LW-1:0] ly1_reg;
    logic [31:0]        rad_prod;
    logic signed [XY_W-1:0] c_next, s_next;
    logic signed [LW-1:0] ly_next;

    assign rad_prod = radius * kin.root;
    assign ly_next  = $signed({{4{origin[31]}}, origin[31:16], 8'b0})
                    + $signed({4'b0, kin.height});

    always_comb
    begin
        unique case (kin.quad)
            QUAD_0:
            begin
                c_next = kin.x;
                s_next = kin.y;
            end
            QUAD_1:
            begin
                c_next = -kin.y;
                s_next = kin.x;
            end
            QUAD_2:
            begin
                c_next = -kin.x;
                s_next = -kin.y;
            end
            default:
            begin
                c_next = kin.y;
                s_next = -kin.x;
            end
        endcase
    end

    // stage 2: distance times cos and sin
    logic               v2_reg;
    logic [15:0]        slot2_reg;
    logic signed [56:0] pcx2_reg, pcz2_reg;
    logic signed [LW-1:0] ly2_reg;

    // stage 3: local point
    logic               v3_reg;
    logic [15:0]        slot3_reg;
    logic signed [LW-1:0] l3_reg [3];

    // stage 4: matrix products, index [axis][column]
    logic               v4_reg;
    logic [15:0]        slot4_reg;
    logic signed [PW-1:0] p4_reg [3][3];

    // stage 5: sums
    logic               v5_reg;
    logic [15:0]        slot5_reg;
    logic signed [AW-1:0] acc5_reg [3];

    // stage 6: shift and saturate
    logic               done_reg;
    logic [15:0]        slot6_reg;
    logic signed [31:0] pos6_reg [3];

    logic signed [LW-1:0] l3_next [3];
    logic signed [AW-1:0] acc_next [3];
    logic signed [31:0]   pos_next [3];

    always_comb
    begin
        l3_next[0] = $signed({{4{origin[15]}}, origin[15:0], 8'b0})
                   + $signed({pcx2_reg[56], pcx2_reg[56:30]});
        l3_next[1] = ly2_reg;
        l3_next[2] = $signed({{4{origin[47]}}, origin[47:32], 8'b0})
                   + $signed({pcz2_reg[56], pcz2_reg[56:30]});
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            acc_next[a] = AW'(p4_reg[a][0]) + AW'(p4_reg[a][1]) + AW'(p4_reg[a][2])
                        + $signed({{9{offset[16*a+15]}}, offset[16*a +: 16], 22'b0});
        end
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            logic signed [AW-15:0] sh;
            sh = acc5_reg[a][AW-1:14];
            if (sh > $signed(33'sh07FFFFFFF))
                pos_next[a] = 32'sh7FFFFFFF;
            else if (sh < $signed(-33'sh080000000))
                pos_next[a] = -32'sh80000000;
            else
                pos_next[a] = sh[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= kin.valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            done_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        slot1_reg <= kin.slot;
        dist1_reg <= rad_prod[31:8];
        c1_reg    <= c_next[31:0];
        s1_reg    <= s_next[31:0];
        ly1_reg   <= ly_next;

        slot2_reg <= slot1_reg;
        pcx2_reg  <= $signed({1'b0, dist1_reg}) * c1_reg;
        pcz2_reg  <= $signed({1'b0, dist1_reg}) * s1_reg;
        ly2_reg   <= ly1_reg;

        slot3_reg <= slot2_reg;
        l3_reg    <= l3_next;

        slot4_reg <= slot3_reg;
        for (int a = 0; a < 3; a++)
        begin
            p4_reg[a][0] <= $signed(row_x[16*a +: 16]) * l3_reg[0];
            p4_reg[a][1] <= $signed(row_y[16*a +: 16]) * l3_reg[1];
            p4_reg[a][2] <= $signed(row_z[16*a +: 16]) * l3_reg[2];
        end

        slot5_reg <= slot4_reg;
        acc5_reg  <= acc_next;

        slot6_reg <= slot5_reg;
        pos6_reg  <= pos_next;
    end

    assign done     = done_reg;
    assign out_slot = slot6_reg;
    assign pos_x    = pos6_reg[0];
    assign pos_y    = pos6_reg[1];
    assign pos_z    = pos6_reg[2];

`ifndef SYNTHESIS
    a_done_delay: assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(kin.valid, 6))
        else $error("result strobe out of step with kernel output");
`endif

endmodule

FILE: bench/cylinder_point_sample_transform_test.sv
module cylinder_point_sample_transform_test;
    import cps_pkg::*;

    localparam int STAGES    = 16;
    localparam int LATENCY   = (STAGES > 16 ? STAGES : 16) + 7;
    localparam int MAX_CYCLES = 400000;

    typedef struct packed {
        logic [15:0] slot;
        logic [15:0] fh;
        logic [15:0] fr;
        logic [15:0] fa;
    } sample_t;

    typedef struct packed {
        logic [15:0]        slot;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } point_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] slot;
    logic [15:0] frac_height;
    logic [15:0] frac_radius;
    logic [15:0] frac_angle;
    logic        wr_en;
    logic [2:0]  wr_index;
    logic [47:0] wr_data;
    logic        done;
    logic [15:0] out_slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;

    cylinder_point_sample_transform #(.CORDIC_STAGES(STAGES)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .slot(slot), .frac_height(frac_height), .frac_radius(frac_radius),
        .frac_angle(frac_angle), .wr_en(wr_en), .wr_index(wr_index),
        .wr_data(wr_data), .done(done), .out_slot(out_slot),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z)
    );

    // predictor copy of the transform registers
    logic [47:0] row_x, row_y, row_z, offset, origin;
    logic [15:0] radius, height;

    sample_t pending_samples[$];
    point_t  expected_points[$];
    bit      failed;
    bit      calm;
    int      cycle_count;
    int      gap_left;

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic signed [63:0] sfield(logic [47:0] packed_val, int which);
        logic signed [15:0] f;
        f = packed_val[16*which +: 16];
        return 64'(f);
    endfunction

    function automatic logic [31:0] root_of(logic [31:0] v);
        logic [31:0] r;
        logic [31:0] b;
        r = 0;
        b = 32'h4000_0000;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic point_t place_point(sample_t s);
        logic signed [63:0] cx, cy, cz, nx, hgt, radial, c, sn, lx, ly, lz, acc;
        logic [1:0] quad;
        logic signed [63:0] atan;
        point_t p;
        int i;
        int ax;
        quad = s.fa[15:14];
        cz = 64'(s.fa[13:0]) << 16;
        cx = 64'(CORDIC_GAIN_Q30);
        cy = 0;
        for (i = 0; i < STAGES && i < ATAN_ENTRIES; i++)
        begin
            atan = 64'(atan_turn(i));
            if (cz >= 0)
            begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                cz = cz - atan;
            end
            else
            begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                cz = cz + atan;
            end
            cx = nx;
        end
        case (quad)
            QUAD_0: begin c = cx;  sn = cy;  end
            QUAD_1: begin c = -cy; sn = cx;  end
            QUAD_2: begin c = -cx; sn = -cy; end
            default: begin c = cy; sn = -cx; end
        endcase
        hgt    = (64'(height) * 64'(s.fh)) >>> 8;
        radial = (64'(radius) * 64'(root_of({s.fr, 16'h0}))) >>> 8;
        lx = sfield(origin, 0) * 256 + ((radial * c) >>> 30);
        ly = sfield(origin, 1) * 256 + hgt;
        lz = sfield(origin, 2) * 256 + ((radial * sn) >>> 30);
        p.slot = s.slot;
        for (ax = 0; ax < 3; ax++)
        begin
            acc = sfield(row_x, ax) * lx + sfield(row_y, ax) * ly
                + sfield(row_z, ax) * lz + (sfield(offset, ax) <<< 22);
            acc = acc >>> 14;
            if (ax == 0)
                p.x = clamp32(acc);
            else if (ax == 1)
                p.y = clamp32(acc);
            else
                p.z = clamp32(acc);
        end
        return p;
    endfunction

    task automatic write_reg(reg_index_t idx, logic [47:0] value);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(negedge clk);
        wr_en    <= 1'b0;
        case (idx)
            REG_ROW_X:  row_x  = value;
            REG_ROW_Y:  row_y  = value;
            REG_ROW_Z:  row_z  = value;
            REG_OFFSET: offset = value;
            REG_ORIGIN: origin = value;
            REG_RADIUS: radius = value[15:0];
            default:    height = value[15:0];
        endcase
    endtask

    task automatic drain;
        while (pending_samples.size() != 0 || expected_points.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [15:0] rand_frac();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000 ^ 16'($urandom_range(0, 3));
            3: return {2'($urandom_range(0, 3)), 14'h0};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_random(int count);
        sample_t s;
        repeat (count)
        begin
            s.slot = 16'($urandom);
            s.fh   = rand_frac();
            s.fr   = rand_frac();
            s.fa   = rand_frac();
            pending_samples.push_back(s);
        end
    endtask

    // driver: one transaction per accepted start, random idle bursts
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
                void'(pending_samples.pop_front());
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 15) == 0)
            begin
                gap_left <= $urandom_range(0, 18);
                start    <= 1'b0;
            end
            else if (pending_samples.size() > ((start && !busy) ? 0 : 0)
                     && !(start && !busy && pending_samples.size() == 0))
            begin
                start       <= 1'b1;
                slot        <= pending_samples[0].slot;
                frac_height <= pending_samples[0].fh;
                frac_radius <= pending_samples[0].fr;
                frac_angle  <= pending_samples[0].fa;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: predict on accept, compare on done
    always @(posedge clk)
    begin
        point_t exp_p;
        if (rst_n)
        begin
            if (start && !busy)
                expected_points.push_back(place_point(
                    {slot, frac_height, frac_radius, frac_angle}));
            if (done)
            begin
                if (expected_points.size() == 0)
                begin
                    $display("%0t: unexpected result slot %h", $time, out_slot);
                    failed = 1'b1;
                end
                else
                begin
                    exp_p = expected_points.pop_front();
                    if (out_slot !== exp_p.slot || pos_x !== exp_p.x
                        || pos_y !== exp_p.y || pos_z !== exp_p.z)
                    begin
                        $display("%0t: mismatch expected %h %h %h %h actual %h %h %h %h",
                                 $time, exp_p.slot, exp_p.x, exp_p.y, exp_p.z,
                                 out_slot, pos_x, pos_y, pos_z);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        sample_t s;
        int ph;
        failed = 1'b0;
        calm = 1'b0;
        cycle_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        slot = '0;
        frac_height = '0;
        frac_radius = '0;
        frac_angle = '0;
        wr_en = 1'b0;
        wr_index = REG_ROW_X;
        wr_data = '0;
        row_x = 48'h0000_0000_4000;
        row_y = 48'h0000_4000_0000;
        row_z = 48'h4000_0000_0000;
        offset = '0;
        origin = '0;
        radius = 16'h0100;
        height = 16'h0100;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes and every quadrant edge
        for (int i = 0; i < 20; i++)
        begin
            s.slot = (i % 2) ? 16'hFFFF : 16'h0000;
            s.fh   = (i % 3 == 0) ? 16'h0000 : 16'hFFFF;
            s.fr   = (i % 4 < 2) ? 16'hFFFF : 16'h0000;
            s.fa   = {2'(i % 4), (i > 9) ? 14'h3FFF : 14'h0};
            pending_samples.push_back(s);
        end
        queue_random(250);
        drain();

        // extremes: largest radius/height and full-scale matrix and offsets
        write_reg(REG_RADIUS, 48'hFFFF);
        write_reg(REG_HEIGHT, 48'hFFFF);
        write_reg(REG_ROW_X, 48'h7FFF_8000_7FFF);
        write_reg(REG_ROW_Y, 48'h8000_7FFF_7FFF);
        write_reg(REG_ROW_Z, 48'h7FFF_7FFF_8000);
        write_reg(REG_OFFSET, 48'h7FFF_8000_7FFF);
        write_reg(REG_ORIGIN, 48'h8000_7FFF_8000);
        queue_random(250);
        drain();

        write_reg(REG_RADIUS, 48'h0);
        write_reg(REG_HEIGHT, 48'h0);
        write_reg(REG_ROW_X, 48'h0);
        write_reg(REG_ROW_Y, 48'h0);
        write_reg(REG_ROW_Z, 48'h0);
        write_reg(REG_OFFSET, 48'h8000_8000_8000);
        write_reg(REG_ORIGIN, 48'hFFFF_FFFF_FFFF);
        queue_random(150);
        drain();

        for (ph = 0; ph < 4; ph++)
        begin
            write_reg(REG_ROW_X, rand48());
            write_reg(REG_ROW_Y, rand48());
            write_reg(REG_ROW_Z, rand48());
            write_reg(REG_OFFSET, rand48());
            write_reg(REG_ORIGIN, rand48());
            write_reg(REG_RADIUS, 48'($urandom_range(0, 65535)));
            write_reg(REG_HEIGHT, 48'($urandom_range(0, 65535)));
            if (ph == 3)
                calm = 1'b1;
            queue_random(250);
            drain();
        end

        if (!failed)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
